// File: src/brhc_pkg.sv
package brhc_pkg;

  localparam int CNT_W = 6;
  localparam int BUF_W = 5;
  localparam int FUNC_W = 4;
  localparam int MAX_BUFFERS_DEF = 32;
  localparam logic [CNT_W-1:0] NUM_BUFFERS_RST = 6'd2;

  typedef enum logic [FUNC_W-1:0] {
    FN_DEQUEUE       = 4'd0,
    FN_UNDO_DEQUEUE  = 4'd1,
    FN_QUEUE         = 4'd2,
    FN_LOCK_CHECK    = 4'd3,
    FN_RETIRE        = 4'd4,
    FN_UNLOCK        = 4'd5,
    FN_REALLOC_ALL   = 4'd6,
    FN_NEED_NEW      = 4'd7,
    FN_REALLOC_CHECK = 4'd8,
    FN_INIT          = 4'd9
  } func_t;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_WOULD_BLOCK     = 3'd1,
    ST_NOT_ENOUGH_DATA = 3'd2,
    ST_BAD_VALUE       = 3'd3,
    ST_BAD_INDEX       = 3'd4
  } op_status_t;

  typedef struct packed {
    logic [BUF_W-1:0] head;
    logic [BUF_W-1:0] tail;
    logic [CNT_W-1:0] avail;
    logic [CNT_W-1:0] queued;
    logic             lock_valid;
    logic [BUF_W-1:0] locked;
  } ring_state_t;

  typedef struct packed {
    op_status_t       status;
    logic [BUF_W-1:0] buffer_out;
    logic             need_flag;
    logic [CNT_W-1:0] available_out;
    logic [CNT_W-1:0] queued_out;
  } result_t;

  localparam int OUT_BITS = 3 + BUF_W + 1 + 2 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Step a ring pointer, wrapping to zero once it reaches the ring size.
  function automatic logic [BUF_W-1:0] ring_advance(input logic [BUF_W-1:0] x,
                                                    input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] nx;
    nx = {1'b0, x} + CNT_W'(1);
    return (nx >= n) ? '0 : nx[BUF_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c,
                                               input logic [CNT_W-1:0] n);
    return (c < n) ? c + CNT_W'(1) : c;
  endfunction

endpackage

// File: src/brhc_engine.sv
module brhc_engine #(
  parameter int MAX_BUFFERS = brhc_pkg::MAX_BUFFERS_DEF
) (
  input  logic [brhc_pkg::CNT_W-1:0]  num_buffers,
  input  logic [brhc_pkg::FUNC_W-1:0] func,
  input  logic [brhc_pkg::BUF_W-1:0]  buffer,
  input  brhc_pkg::ring_state_t       state_q,
  input  logic [MAX_BUFFERS-1:0]      realloc_q,
  output brhc_pkg::ring_state_t       state_d,
  output logic [MAX_BUFFERS-1:0]      realloc_d,
  output brhc_pkg::result_t           result
);
  import brhc_pkg::*;

  localparam int RW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_BUFFERS);

  logic [CNT_W-1:0]       n;
  logic                   indexed;
  logic [MAX_BUFFERS-1:0] fill_mask;
  logic [RW-1:0]          bit_sel;
  logic [BUF_W-1:0]       new_head;

  always_comb begin
    if (num_buffers == '0) begin
      n = CNT_W'(1);
    end else if (num_buffers > MAX_N) begin
      n = MAX_N;
    end else begin
      n = num_buffers;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_BUFFERS; i++) begin
      fill_mask[i] = (CNT_W'(i) < n);
    end
  end

  // Only in-range indices reach the bit select, so the low bits suffice.
  assign bit_sel = buffer[RW-1:0];
  assign new_head = ring_advance(state_q.head, n);
  assign indexed = (func == FN_LOCK_CHECK) || (func == FN_UNLOCK) ||
                   (func == FN_NEED_NEW) || (func == FN_REALLOC_CHECK);

  always_comb begin
    state_d = state_q;
    realloc_d = realloc_q;
    result.status = ST_OK;
    result.buffer_out = '0;
    result.need_flag = 1'b0;
    if (indexed && ({1'b0, buffer} >= n)) begin
      result.status = ST_BAD_INDEX;
    end else begin
      unique case (func)
        FN_DEQUEUE: begin
          if (state_q.avail == '0) begin
            result.status = ST_WOULD_BLOCK;
          end else begin
            state_d.avail = state_q.avail - CNT_W'(1);
            result.buffer_out = state_q.tail;
            state_d.tail = ring_advance(state_q.tail, n);
          end
        end
        FN_UNDO_DEQUEUE: state_d.avail = sat_inc(state_q.avail, n);
        FN_QUEUE: state_d.queued = sat_inc(state_q.queued, n);
        FN_LOCK_CHECK: begin
          if (buffer == state_q.head &&
              !(state_q.queued != '0 &&
                !(state_q.lock_valid && state_q.locked == buffer))) begin
            result.status = ST_WOULD_BLOCK;
          end
        end
        FN_RETIRE: begin
          state_d.lock_valid = 1'b1;
          state_d.locked = state_q.head;
          if (state_q.queued == '0) begin
            result.status = ST_NOT_ENOUGH_DATA;
          end else begin
            state_d.queued = state_q.queued - CNT_W'(1);
            state_d.head = new_head;
            state_d.locked = new_head;
            state_d.avail = sat_inc(state_q.avail, n);
            result.buffer_out = new_head;
          end
        end
        FN_UNLOCK: begin
          if (!state_q.lock_valid || state_q.locked != buffer) begin
            result.status = ST_BAD_VALUE;
          end else begin
            state_d.lock_valid = 1'b0;
          end
        end
        FN_REALLOC_ALL: realloc_d = realloc_q | fill_mask;
        FN_NEED_NEW: begin
          result.need_flag = realloc_q[bit_sel];
          realloc_d[bit_sel] = 1'b0;
        end
        FN_REALLOC_CHECK: begin
          if (buffer == state_q.head) begin
            result.status = ST_WOULD_BLOCK;
          end
        end
        FN_INIT: begin
          state_d.head = BUF_W'(n - CNT_W'(1));
          state_d.tail = '0;
          state_d.avail = n;
          state_d.queued = '0;
          state_d.lock_valid = 1'b0;
          state_d.locked = '0;
          realloc_d = '0;
        end
        default: result.status = ST_BAD_VALUE;
      endcase
    end
    result.available_out = state_d.avail;
    result.queued_out = state_d.queued;
  end

endmodule

// File: src/buffer_ring_handoff_controller_core.sv
// Path: a beat accepted on the slave side goes through the input register, then
// the result register, before its result is offered on the master side.
// Throughput: one operation per cycle while m_tready does not stall the output;
// the input register lets the next beat in while a result still waits for m_tready.
// Reset (rst, synchronous, active high) sets num_buffers to 2, head to 1,
// available to 2, clears everything else and empties both registers.
module buffer_ring_handoff_controller_core #(
  parameter int MAX_BUFFERS = brhc_pkg::MAX_BUFFERS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // [4:0] buffer
  input  logic [brhc_pkg::FUNC_W-1:0]      s_tuser,  // [3:0] func
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [2:0] status, [7:3] buffer_out, [8] need_flag, [14:9] available_out,
  // [20:15] queued_out
  output logic [brhc_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [brhc_pkg::CNT_W-1:0]       cfg_data
);
  import brhc_pkg::*;

  logic [CNT_W-1:0]       num_buffers;
  ring_state_t            ring_state;
  ring_state_t            ring_state_next;
  logic [MAX_BUFFERS-1:0] realloc_bits;
  logic [MAX_BUFFERS-1:0] realloc_bits_next;
  logic                   s1_valid;
  logic [FUNC_W-1:0]      s1_func;
  logic [BUF_W-1:0]       s1_buffer;
  logic                   s1_fire;
  result_t                result;
  logic                   out_valid;
  logic [OUT_DATA_W-1:0]  out_data;

  assign cfg_ready = 1'b1;
  assign s1_fire = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_fire;
  assign m_tvalid = out_valid;
  assign m_tdata = out_data;

  brhc_engine #(.MAX_BUFFERS(MAX_BUFFERS)) u_engine (
    .num_buffers (num_buffers),
    .func        (s1_func),
    .buffer      (s1_buffer),
    .state_q     (ring_state),
    .realloc_q   (realloc_bits),
    .state_d     (ring_state_next),
    .realloc_d   (realloc_bits_next),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_buffers <= NUM_BUFFERS_RST;
    end else if (cfg_valid && cfg_ready) begin
      num_buffers <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_state.head <= BUF_W'(NUM_BUFFERS_RST - CNT_W'(1));
      ring_state.tail <= '0;
      ring_state.avail <= NUM_BUFFERS_RST;
      ring_state.queued <= '0;
      ring_state.lock_valid <= 1'b0;
      ring_state.locked <= '0;
      realloc_bits <= '0;
    end else if (s1_fire) begin
      ring_state <= ring_state_next;
      realloc_bits <= realloc_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_func <= s_tuser;
      s1_buffer <= s_tdata[BUF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= OUT_DATA_W'({result.queued_out, result.available_out,
                               result.need_flag, result.buffer_out,
                               result.status});
    end
  end

endmodule

// File: src/brhc_checker.sv
module brhc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [brhc_pkg::OUT_DATA_W-1:0] m_tdata
);
  import brhc_pkg::*;

  logic [2:0] st;
  assign st = m_tdata[2:0];

  // A result beat always carries one of the defined status codes.
  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (st == ST_OK || st == ST_WOULD_BLOCK || st == ST_NOT_ENOUGH_DATA ||
                  st == ST_BAD_VALUE || st == ST_BAD_INDEX))
    else $error("status code out of range");

  // A returned buffer or a set need flag only comes with a successful beat.
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[7:3] != '0 || m_tdata[8])) |-> st == ST_OK)
    else $error("buffer or need flag on a failed operation");

  // A waiting result beat stays valid and unchanged until the master side takes it.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  // No result appears right after reset, before any beat could pass through.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // A beat taken with the output side free passes both registers, then shows up.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) ##1 (!m_tvalid) |=> m_tvalid)
    else $error("result did not arrive");

endmodule

bind buffer_ring_handoff_controller_core brhc_checker u_brhc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
